// ----- design/gsam_pkg.sv -----
`timescale 1ns / 1ps

package gsam_pkg;

  localparam int MV_W           = 12;
  localparam int COUNT_W        = 8;
  localparam int BLINK_ON_W     = 4;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 12;
  localparam int BLINK_PERIOD_DEF = 10;

  // Exact floor(x / 10) for any 16-bit x: (x * 0xCCCD) >> 19.
  localparam int          DIV10_SUM_W = 16;
  localparam logic [15:0] DIV10_MUL   = 16'hCCCD;
  localparam int          DIV10_SHIFT = 19;

  typedef enum logic [1:0] {
    ST_NOT_READY = 2'd0,
    ST_WARNING   = 2'd1,
    ST_ALARM     = 2'd2,
    ST_NORMAL    = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEATER_TARGET = 3'd0,
    CFG_HEATER_BAND   = 3'd1,
    CFG_WARN_LEVEL    = 3'd2,
    CFG_ALARM_LEVEL   = 3'd3,
    CFG_SPIKE_JUMP    = 3'd4,
    CFG_SPIKE_REJECT  = 3'd5,
    CFG_WARMUP        = 3'd6,
    CFG_BLINK_ON      = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [MV_W-1:0]       heater_target;
    logic [MV_W-1:0]       heater_band;
    logic [MV_W-1:0]       warn_level;
    logic [MV_W-1:0]       alarm_level;
    logic [MV_W-1:0]       spike_jump;
    logic [MV_W-1:0]       spike_reject;
    logic [COUNT_W-1:0]    warmup;
    logic [BLINK_ON_W-1:0] blink_on;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    heater_target: 12'd500,
    heater_band:   12'd15,
    warn_level:    12'd2700,
    alarm_level:   12'd2800,
    spike_jump:    12'd100,
    spike_reject:  12'd300,
    warmup:        8'd10,
    blink_on:      4'd2
  };

  typedef struct packed {
    status_t status;
    logic    alarm_pin;
  } class_res_t;

  typedef struct packed {
    logic [MV_W-1:0] filtered;
    logic            rejected;
  } filt_res_t;

endpackage

// ----- design/gsam_classifier.sv -----
`timescale 1ns / 1ps

module gsam_classifier #(
  parameter int BLINK_PERIOD = gsam_pkg::BLINK_PERIOD_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          advance,
  input  logic [gsam_pkg::MV_W-1:0]     heater_mv,
  input  logic [gsam_pkg::MV_W-1:0]     sensor_mv,
  input  gsam_pkg::cfg_t                cfg,
  output gsam_pkg::class_res_t          res
);

  localparam int PHASE_W = $clog2(BLINK_PERIOD);

  logic [PHASE_W-1:0]        blink_phase_r;
  logic [PHASE_W-1:0]        blink_phase_nxt;
  logic [gsam_pkg::MV_W-1:0] dev;
  logic                      in_alarm;
  logic [4:0]                phase_inc;

  always_comb begin
    if (heater_mv >= cfg.heater_target) begin
      dev = heater_mv - cfg.heater_target;
    end else begin
      dev = cfg.heater_target - heater_mv;
    end

    in_alarm      = 1'b0;
    res.alarm_pin = 1'b0;
    if (dev > cfg.heater_band) begin
      res.status = gsam_pkg::ST_NOT_READY;
    end else if (sensor_mv > cfg.warn_level && sensor_mv < cfg.alarm_level) begin
      res.status = gsam_pkg::ST_WARNING;
    end else if (sensor_mv > cfg.alarm_level) begin
      res.status    = gsam_pkg::ST_ALARM;
      in_alarm      = 1'b1;
      res.alarm_pin = 5'(blink_phase_r) < 5'(cfg.blink_on);
    end else begin
      res.status = gsam_pkg::ST_NORMAL;
    end

    phase_inc = 5'(blink_phase_r) + 5'd1;
    if (!in_alarm) begin
      blink_phase_nxt = blink_phase_r;
    end else if (phase_inc >= 5'(BLINK_PERIOD)) begin
      blink_phase_nxt = '0;
    end else begin
      blink_phase_nxt = PHASE_W'(phase_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_phase_r <= '0;
    end else if (advance) begin
      blink_phase_r <= blink_phase_nxt;
    end
  end

endmodule

// ----- design/gsam_filter.sv -----
`timescale 1ns / 1ps

module gsam_filter (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      advance,
  input  logic [gsam_pkg::MV_W-1:0] heater_mv,
  input  gsam_pkg::cfg_t            cfg,
  output gsam_pkg::filt_res_t       res
);

  logic [gsam_pkg::MV_W-1:0]        filt_r;
  logic [gsam_pkg::MV_W-1:0]        filt_nxt;
  logic [gsam_pkg::COUNT_W-1:0]     count_r;
  logic [gsam_pkg::COUNT_W-1:0]     count_nxt;
  logic [gsam_pkg::MV_W-1:0]        rise;
  logic                             active;
  logic                             jump;
  logic                             reject;
  logic [gsam_pkg::DIV10_SUM_W-1:0] sum;
  logic [31:0]                      prod;

  always_comb begin
    active = count_r > cfg.warmup;
    // Only an upward step can exceed a threshold, so an unsigned rise works.
    rise   = heater_mv - filt_r;
    jump   = (heater_mv > filt_r) && (rise > cfg.spike_jump);
    reject = jump && (rise > cfg.spike_reject);

    // floor((heater + 9 * filt) / 10) by reciprocal multiply.
    sum  = 16'(heater_mv) + 16'({filt_r, 3'b000}) + 16'(filt_r);
    prod = 32'(sum) * 32'(gsam_pkg::DIV10_MUL);

    res.rejected = 1'b0;
    if (active && jump) begin
      if (reject) begin
        filt_nxt     = filt_r;
        res.rejected = 1'b1;
      end else begin
        filt_nxt = prod[gsam_pkg::DIV10_SHIFT +: gsam_pkg::MV_W];
      end
    end else begin
      filt_nxt = heater_mv;
    end
    res.filtered = filt_nxt;

    // Saturate at warmup + 1, but never past the top of the counter.
    if (count_r <= cfg.warmup && count_r != '1) begin
      count_nxt = count_r + 1'b1;
    end else begin
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r  <= '0;
      count_r <= '0;
    end else if (advance) begin
      filt_r  <= filt_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// ----- design/gas_sensor_alarm_monitor_top.sv -----
`timescale 1ns / 1ps
// An input transaction accepted into the input register moves its result into the output
// register once that register is free, which raises out_valid. Throughput: one transaction
// per cycle unless the result side stalls, set by the single compute stage between the two
// registers; the divide by ten is a single 16 x 16 reciprocal multiply in that stage.
// Reset (rst_n low, synchronous): both valid flags clear, the filter, sample count and blink
// phase go to zero and the configuration registers take their default values.

module gas_sensor_alarm_monitor_top #(
  parameter int BLINK_PERIOD = gsam_pkg::BLINK_PERIOD_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [gsam_pkg::MV_W-1:0]       in_heater_mv,
  input  logic [gsam_pkg::MV_W-1:0]       in_sensor_mv,
  // Result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_status,
  output logic                            out_alarm_pin,
  output logic [gsam_pkg::MV_W-1:0]       out_filtered_heater_mv,
  output logic                            out_sample_rejected,
  // Configuration write port
  input  logic                            cfg_we,
  input  logic [gsam_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gsam_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers: write only while the block is idle; the block does not enforce it.
  gsam_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= gsam_pkg::CFG_RESET;
    end else if (cfg_we) begin
      unique case (gsam_pkg::cfg_idx_t'(cfg_index))
        gsam_pkg::CFG_HEATER_TARGET: cfg_r.heater_target <= cfg_wdata;
        gsam_pkg::CFG_HEATER_BAND:   cfg_r.heater_band   <= cfg_wdata;
        gsam_pkg::CFG_WARN_LEVEL:    cfg_r.warn_level    <= cfg_wdata;
        gsam_pkg::CFG_ALARM_LEVEL:   cfg_r.alarm_level   <= cfg_wdata;
        gsam_pkg::CFG_SPIKE_JUMP:    cfg_r.spike_jump    <= cfg_wdata;
        gsam_pkg::CFG_SPIKE_REJECT:  cfg_r.spike_reject  <= cfg_wdata;
        gsam_pkg::CFG_WARMUP:        cfg_r.warmup        <= cfg_wdata[gsam_pkg::COUNT_W-1:0];
        gsam_pkg::CFG_BLINK_ON:      cfg_r.blink_on      <= cfg_wdata[gsam_pkg::BLINK_ON_W-1:0];
        default: ;
      endcase
    end
  end

  // Two-register pipeline. The output register frees itself when its transaction is
  // taken, and the input register moves forward whenever the output register is free,
  // so a new transaction is accepted every cycle unless the result side stalls.
  logic                      s1_valid_r;
  logic [gsam_pkg::MV_W-1:0] s1_heater_r;
  logic [gsam_pkg::MV_W-1:0] s1_sensor_r;
  logic                      out_free;
  logic                      advance;

  assign out_free = !out_valid || out_ready;
  assign advance  = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_heater_r <= in_heater_mv;
      s1_sensor_r <= in_sensor_mv;
    end
  end

  // Compute stage. Each unit keeps its own running state and commits it only when the
  // transaction in the input register moves into the output register.
  gsam_pkg::class_res_t cls_res;
  gsam_pkg::filt_res_t  flt_res;

  gsam_classifier #(
    .BLINK_PERIOD (BLINK_PERIOD)
  ) u_classifier (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .heater_mv (s1_heater_r),
    .sensor_mv (s1_sensor_r),
    .cfg       (cfg_r),
    .res       (cls_res)
  );

  gsam_filter u_filter (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .heater_mv (s1_heater_r),
    .cfg       (cfg_r),
    .res       (flt_res)
  );

  // Output register.
  logic                 out_valid_r;
  gsam_pkg::class_res_t out_cls_r;
  gsam_pkg::filt_res_t  out_flt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_cls_r <= cls_res;
      out_flt_r <= flt_res;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_status             = out_cls_r.status;
  assign out_alarm_pin          = out_cls_r.alarm_pin;
  assign out_filtered_heater_mv = out_flt_r.filtered;
  assign out_sample_rejected    = out_flt_r.rejected;

endmodule

// ----- design/gsam_checker.sv -----
`timescale 1ns / 1ps

module gsam_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [1:0]                out_status,
  input logic                      out_alarm_pin,
  input logic [gsam_pkg::MV_W-1:0] out_filtered_heater_mv,
  input logic                      out_sample_rejected
);

  // Reset empties the result side.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // The input side only stalls when a finished result is waiting.
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("in_ready low without a stalled result");

  // The alarm pin is only driven in the alarm state.
  a_pin_alarm: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_alarm_pin) |-> (out_status == gsam_pkg::ST_ALARM))
    else $error("alarm pin high outside alarm");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_status)
      && $stable(out_alarm_pin) && $stable(out_filtered_heater_mv)
      && $stable(out_sample_rejected)))
    else $error("stalled result changed");

endmodule

bind gas_sensor_alarm_monitor_top gsam_checker u_gsam_checker (.*);

// ----- tb/gas_sensor_alarm_monitor_top_tb.sv -----
`timescale 1ns / 1ps

module gas_sensor_alarm_monitor_top_tb;
  import gsam_pkg::*;

  localparam int BLINK_PERIOD = BLINK_PERIOD_DEF;
  localparam int ERR_PRINT_CAP = 40;

  // One input transaction and one expected result transaction.
  typedef struct {
    logic [MV_W-1:0] heater;
    logic [MV_W-1:0] sensor;
  } reading_t;

  typedef struct {
    status_t         status;
    logic            pin;
    logic [MV_W-1:0] filtered;
    logic            rejected;
  } verdict_t;

  // Receiver back-pressure styles; the monitor switches between them at random.
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_PERIODIC,
    RX_BURSTY
  } rx_mode_t;

  // Clock, reset and every block input start at a known value.
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [MV_W-1:0]       in_heater_mv = '0;
  logic [MV_W-1:0]       in_sensor_mv = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [1:0]            out_status;
  logic                  out_alarm_pin;
  logic [MV_W-1:0]       out_filtered_heater_mv;
  logic                  out_sample_rejected;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  gas_sensor_alarm_monitor_top #(
    .BLINK_PERIOD(BLINK_PERIOD)
  ) DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_heater_mv          (in_heater_mv),
    .in_sensor_mv          (in_sensor_mv),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_status            (out_status),
    .out_alarm_pin         (out_alarm_pin),
    .out_filtered_heater_mv(out_filtered_heater_mv),
    .out_sample_rejected   (out_sample_rejected),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Hard stop in case the handshakes lock up.
  initial begin
    #1_000_000;
    $display("Timeout: the block stopped moving transactions.");
    $display("[FAIL] regression broken");
    $finish;
  end

  // Shadow of the block: the configuration it holds and its three state registers.
  cfg_t                  live_cfg = CFG_RESET;
  logic [MV_W-1:0]       filt_mv = '0;
  logic [COUNT_W-1:0]    warm_count = '0;
  logic [3:0]            blink_phase = '0;

  reading_t pending_readings[$];
  verdict_t expected_verdicts[$];

  int mismatch_count = 0;
  int accepted_count = 0;
  int verdict_count = 0;
  int settings_count = 1;
  int alarm_count = 0;
  int pin_high_count = 0;
  int warning_count = 0;
  int not_ready_count = 0;
  int smooth_count = 0;
  int reject_count = 0;

  // Generator memory: the last heater value queued, used to aim jumps at the filter.
  int gen_prev_heater = 0;

  task automatic flag_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= ERR_PRINT_CAP) begin
      $display("%0t: mismatch on %s after %0d results: got %0d, want %0d", $realtime, what,
               verdict_count, got, want);
    end
  endtask

  // Computes the result of one accepted transaction and advances the shadow state.
  // Classification and filtering both use the same item; the sample count is
  // taken before this item when deciding whether the filter is active.
  function automatic void predict_reading(input logic [MV_W-1:0] heater,
                                          input logic [MV_W-1:0] sensor);
    verdict_t v;
    int       dev;
    int       rise;
    int       sat;
    v.status   = ST_NORMAL;
    v.pin      = 1'b0;
    v.rejected = 1'b0;

    dev = int'(heater) - int'(live_cfg.heater_target);
    if (dev < 0) dev = -dev;
    if (dev > int'(live_cfg.heater_band)) begin
      v.status = ST_NOT_READY;
      not_ready_count++;
    end else if (sensor > live_cfg.warn_level && sensor < live_cfg.alarm_level) begin
      v.status = ST_WARNING;
      warning_count++;
    end else if (sensor > live_cfg.alarm_level) begin
      v.status = ST_ALARM;
      v.pin = (blink_phase < live_cfg.blink_on);
      blink_phase = (int'(blink_phase) + 1 >= BLINK_PERIOD) ? 4'd0 : blink_phase + 4'd1;
      alarm_count++;
      if (v.pin) pin_high_count++;
    end

    rise = int'(heater) - int'(filt_mv);
    if (warm_count > live_cfg.warmup && rise > int'(live_cfg.spike_jump)) begin
      if (rise > int'(live_cfg.spike_reject)) begin
        v.rejected = 1'b1;
        reject_count++;
      end else begin
        filt_mv = MV_W'((int'(heater) + 9 * int'(filt_mv)) / 10);
        smooth_count++;
      end
    end else begin
      filt_mv = heater;
    end
    v.filtered = filt_mv;

    sat = int'(live_cfg.warmup) + 1;
    if (sat > 255) sat = 255;
    if (int'(warm_count) < sat) warm_count = warm_count + 1'b1;

    expected_verdicts.push_back(v);
  endfunction

  function automatic logic [MV_W-1:0] clamp_mv(input int v);
    if (v < 0) return '0;
    if (v > 4095) return '1;
    return MV_W'(v);
  endfunction

  // Random reading shaped around the live thresholds: most heater values sit
  // on or near the ready band or jump from the last one by about the spike
  // thresholds, most sensor values at, between or above warn and alarm levels.
  function automatic reading_t next_reading();
    reading_t r;
    int       step;
    int       warn;
    int       alarm;
    warn  = int'(live_cfg.warn_level);
    alarm = int'(live_cfg.alarm_level);

    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        case ($urandom_range(0, 2))
          0: step = int'(live_cfg.heater_band);
          1: step = int'(live_cfg.heater_band) + 1;
          default: step = $urandom_range(0, int'(live_cfg.heater_band));
        endcase
        if ($urandom_range(0, 1) == 1) step = -step;
        r.heater = clamp_mv(int'(live_cfg.heater_target) + step);
      end
      5, 6, 7: begin
        case ($urandom_range(0, 5))
          0: step = int'(live_cfg.spike_jump);
          1: step = int'(live_cfg.spike_jump) + 1;
          2: step = int'(live_cfg.spike_reject);
          3: step = int'(live_cfg.spike_reject) + 1;
          4: step = $urandom_range(0, 600);
          default: step = -int'($urandom_range(0, 400));
        endcase
        r.heater = clamp_mv(gen_prev_heater + step);
      end
      default: r.heater = MV_W'($urandom_range(0, 4095));
    endcase

    case ($urandom_range(0, 7))
      0: r.sensor = clamp_mv(warn + int'($urandom_range(0, 2)) - 1);
      1: r.sensor = clamp_mv(alarm + int'($urandom_range(0, 2)) - 1);
      2: r.sensor = (alarm > warn) ? MV_W'($urandom_range(warn, alarm)) : MV_W'(warn);
      3, 4: r.sensor = MV_W'($urandom_range(alarm, 4095));
      default: r.sensor = MV_W'($urandom_range(0, 4095));
    endcase

    gen_prev_heater = int'(r.heater);
    return r;
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.heater_target = MV_W'($urandom_range(100, 4000));
    c.heater_band   = MV_W'($urandom_range(0, 300));
    c.warn_level    = MV_W'($urandom_range(0, 3900));
    c.alarm_level   = clamp_mv(int'(c.warn_level) + int'($urandom_range(0, 195)));
    c.spike_jump    = MV_W'($urandom_range(0, 400));
    // Now and then the reject threshold falls to or below the smoothing one.
    if ($urandom_range(0, 4) == 0) begin
      c.spike_reject = MV_W'($urandom_range(0, int'(c.spike_jump)));
    end else begin
      c.spike_reject = clamp_mv(int'(c.spike_jump) + int'($urandom_range(0, 600)));
    end
    c.warmup   = COUNT_W'($urandom_range(0, 30));
    c.blink_on = BLINK_ON_W'($urandom_range(0, 15));
    return c;
  endfunction

  // Waits at falling edges (settled values) until the sender is empty and nothing
  // is in flight, then gives the output register time to drain.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_readings.size() != 0 || in_valid || expected_verdicts.size() != 0);
    repeat (2) @(negedge clk);
  endtask

  // Writes all eight registers back to back while the block is idle. The upper
  // data bits of the narrow registers carry junk that the block must drop.
  task automatic program_cfg(input cfg_t c);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_HEATER_TARGET;
    cfg_wdata <= c.heater_target;
    @(posedge clk);
    cfg_index <= CFG_HEATER_BAND;
    cfg_wdata <= c.heater_band;
    @(posedge clk);
    cfg_index <= CFG_WARN_LEVEL;
    cfg_wdata <= c.warn_level;
    @(posedge clk);
    cfg_index <= CFG_ALARM_LEVEL;
    cfg_wdata <= c.alarm_level;
    @(posedge clk);
    cfg_index <= CFG_SPIKE_JUMP;
    cfg_wdata <= c.spike_jump;
    @(posedge clk);
    cfg_index <= CFG_SPIKE_REJECT;
    cfg_wdata <= c.spike_reject;
    @(posedge clk);
    cfg_index <= CFG_WARMUP;
    cfg_wdata <= {4'($urandom), c.warmup};
    @(posedge clk);
    cfg_index <= CFG_BLINK_ON;
    cfg_wdata <= {8'($urandom), c.blink_on};
    @(posedge clk);
    cfg_we <= 1'b0;
    live_cfg = c;
    settings_count++;
    @(negedge clk);
  endtask

  task automatic queue_reading(input int heater, input int sensor);
    reading_t r;
    r.heater = MV_W'(heater);
    r.sensor = MV_W'(sensor);
    pending_readings.push_back(r);
  endtask

  // Half the phase, a full drain with the sender holding off, then the rest.
  task automatic run_phase(input int n);
    for (int i = 0; i < n; i++) begin
      pending_readings.push_back(next_reading());
      if (i == n / 2) wait_idle();
    end
    wait_idle();
  endtask

  // Driver: bursts of random length separated by random gaps. A held
  // transaction keeps valid and its payload until the block takes it.
  int burst_left = 0;
  int gap_left = 0;
  reading_t drive_item;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_reading(in_heater_mv, in_sensor_mv);
        accepted_count++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_readings.size() != 0) begin
          drive_item = pending_readings.pop_front();
          in_valid     <= 1'b1;
          in_heater_mv <= drive_item.heater;
          in_sensor_mv <= drive_item.sensor;
          if (burst_left <= 1) begin
            // Some bursts run long with no gap at all behind them.
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                      : $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every accepted result against the oldest expectation and
  // drives out_ready from a back-pressure pattern that changes now and then.
  verdict_t want;
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_timer = 0;
  int       rx_tick = 0;
  int       rx_run = 0;
  logic     rx_low = 1'b0;
  logic     rx_next;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_verdicts.size() == 0) begin
        flag_mismatch("result with no transaction outstanding", 1, 0);
      end else begin
        want = expected_verdicts.pop_front();
        if (out_status !== want.status)
          flag_mismatch("status", int'(out_status), int'(want.status));
        if (out_alarm_pin !== want.pin)
          flag_mismatch("alarm_pin", int'(out_alarm_pin), int'(want.pin));
        if (out_filtered_heater_mv !== want.filtered)
          flag_mismatch("filtered_heater_mv", int'(out_filtered_heater_mv),
                        int'(want.filtered));
        if (out_sample_rejected !== want.rejected)
          flag_mismatch("sample_rejected", int'(out_sample_rejected), int'(want.rejected));
        verdict_count++;
      end
    end

    if (rx_timer == 0) begin
      rx_mode  = rx_mode_t'($urandom_range(0, 3));
      rx_timer = $urandom_range(40, 300);
    end else begin
      rx_timer--;
    end
    case (rx_mode)
      RX_OPEN:     rx_next = 1'b1;
      RX_COIN:     rx_next = 1'($urandom_range(0, 1));
      RX_PERIODIC: rx_next = (rx_tick % 3) != 0;
      default: begin
        if (rx_run == 0) begin
          rx_low = !rx_low;
          rx_run = rx_low ? $urandom_range(1, 12) : $urandom_range(1, 8);
        end else begin
          rx_run--;
        end
        rx_next = !rx_low;
      end
    endcase
    rx_tick++;
    out_ready <= rx_next;
  end

  cfg_t setting;

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed transactions under the reset configuration (target 500, band 15,
    // warning above 2700, alarm above 2800, jump 100, reject 300, warm-up 10).
    queue_reading(0, 0);          // all-zero fields, heater far off target
    queue_reading(4095, 4095);    // all-ones fields
    queue_reading(500, 0);        // normal
    queue_reading(515, 2700);     // upper band edge, sensor equal to warning level
    queue_reading(485, 2701);     // lower band edge, warning
    queue_reading(516, 2799);     // just outside the band above
    queue_reading(484, 2800);     // just outside the band below
    queue_reading(500, 2800);     // sensor equal to alarm level stays normal
    queue_reading(500, 2799);     // warning
    // Twelve alarms in a row walk the blink phase through its wrap.
    for (int i = 0; i < 12; i++) begin
      queue_reading(500, (i % 2 == 0) ? 2801 : 4095);
    end
    // The filter is now active: jump exactly at the smoothing threshold, just
    // over it, exactly at the reject threshold, just over it, then a drop.
    queue_reading(600, 0);
    queue_reading(701, 0);
    queue_reading(910, 0);
    queue_reading(941, 0);
    queue_reading(0, 0);
    gen_prev_heater = 0;
    wait_idle();

    run_phase(250);

    program_cfg(random_cfg());
    run_phase(250);

    // Everything at zero: only heater 0 is ready, any nonzero sensor alarms
    // with the pin held low, and every upward heater step is rejected.
    setting = '0;
    program_cfg(setting);
    run_phase(200);

    // Everything at its top value: the heater is always ready, the sensor can
    // never exceed the levels, and the filter wakes up once the sample count reaches 255.
    setting.heater_target = '1;
    setting.heater_band   = '1;
    setting.warn_level    = '1;
    setting.alarm_level   = '1;
    setting.spike_jump    = '1;
    setting.spike_reject  = '1;
    setting.warmup        = 8'd254;
    setting.blink_on      = '1;
    program_cfg(setting);
    run_phase(300);

    // Warm-up of 255 keeps the filter off for good; reject below jump and a
    // warning level above the alarm level are both inverted.
    setting.heater_target = 12'd2048;
    setting.heater_band   = 12'd100;
    setting.warn_level    = 12'd3000;
    setting.alarm_level   = 12'd1000;
    setting.spike_jump    = 12'd150;
    setting.spike_reject  = 12'd40;
    setting.warmup        = 8'd255;
    setting.blink_on      = 4'd15;
    program_cfg(setting);
    run_phase(200);

    // The sample count sits at 255, so a short warm-up makes the filter active
    // at once without any new warm-up.
    setting = random_cfg();
    setting.warmup = 8'd3;
    program_cfg(setting);
    run_phase(200);

    program_cfg(random_cfg());
    run_phase(250);

    program_cfg(random_cfg());
    run_phase(250);

    wait_idle();
    repeat (4) @(posedge clk);
    $display("Run covered %0d transactions and %0d results over %0d register settings.",
             accepted_count, verdict_count, settings_count);
    $display("Seen: %0d alarm (%0d pin), %0d warn, %0d not ready, %0d smoothed, %0d rejected.",
             alarm_count, pin_high_count, warning_count, not_ready_count, smooth_count,
             reject_count);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches found.", mismatch_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- gas_sensor_alarm_monitor_top.f -----
design/gsam_pkg.sv
design/gsam_classifier.sv
design/gsam_filter.sv
design/gas_sensor_alarm_monitor_top.sv
design/gsam_checker.sv
tb/gas_sensor_alarm_monitor_top_tb.sv
